[src/assert_macros.svh]
// Assertion macros used by the filter top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, masked while in reset
`define IIRRN_ASSERT_IMP(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, masked while in reset
`define IIRRN_ASSERT_NXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[src/iirrn_pkg.sv]
// Package: types, register map, operand codes and microcode for the filter.
`timescale 1ns / 1ps

package iirrn_pkg;

    // Sizes
    localparam int TAPS   = 4;
    localparam int NREGS  = 8;
    localparam int DW     = 16;
    localparam int PCW    = 4;
    localparam int QW     = 17;
    localparam int CNTW   = 5;
    localparam logic [CNTW-1:0] DIV_ITERS_M1 = CNTW'(QW - 1);

    // Register map
    localparam logic [2:0] REG_B_TAP0 = 3'd0;
    localparam logic [2:0] REG_B_TAP1 = 3'd1;
    localparam logic [2:0] REG_B_TAP2 = 3'd2;
    localparam logic [2:0] REG_B_TAP3 = 3'd3;
    localparam logic [2:0] REG_A_TAP0 = 3'd4;
    localparam logic [2:0] REG_A_TAP1 = 3'd5;
    localparam logic [2:0] REG_A_TAP2 = 3'd6;
    localparam logic [2:0] REG_A_TAP3 = 3'd7;

    // Multiplier operand codes
    localparam logic [2:0] OPD_X  = 3'd0;
    localparam logic [2:0] OPD_X1 = 3'd1;
    localparam logic [2:0] OPD_X2 = 3'd2;
    localparam logic [2:0] OPD_X3 = 3'd3;
    localparam logic [2:0] OPD_Y1 = 3'd4;
    localparam logic [2:0] OPD_Y2 = 3'd5;
    localparam logic [2:0] OPD_Y3 = 3'd6;

    typedef logic [NREGS-1:0][DW-1:0] coef_bank_t;

    typedef enum logic [2:0] {
        UOP_WAIT = 3'd0,
        UOP_MUL  = 3'd1,
        UOP_ACC  = 3'd2,
        UOP_PREP = 3'd3,
        UOP_DIV  = 3'd4,
        UOP_DONE = 3'd5
    } uop_t;

    typedef enum logic [1:0] {
        ACC_NONE = 2'd0,
        ACC_ADD  = 2'd1,
        ACC_SUB  = 2'd2
    } acc_op_t;

    typedef enum logic [1:0] {
        JMP_NEXT     = 2'd0,
        JMP_WAIT_IN  = 2'd1,
        JMP_LOOP_DIV = 2'd2,
        JMP_WAIT_OUT = 2'd3
    } jmp_t;

    // One control word
    typedef struct packed {
        uop_t           uop;
        logic [2:0]     coef_sel;
        logic [2:0]     data_sel;
        acc_op_t        acc_op;
        jmp_t           jmp;
        logic [PCW-1:0] target;
    } uword_t;

    // Status fed back to the sequencer
    typedef struct packed {
        logic in_fire;
        logic commit;
        logic div_last;
    } seq_stat_t;

    localparam logic [PCW-1:0] PC_HOME = '0;

    // Microcode ROM. Products are registered, so each accumulating step takes
    // the product formed by the step before it.
    function automatic uword_t ucode(input logic [PCW-1:0] pc);
        uword_t w;
        w = '{uop: UOP_WAIT, coef_sel: REG_B_TAP0, data_sel: OPD_X,
              acc_op: ACC_NONE, jmp: JMP_WAIT_IN, target: PC_HOME};
        unique case (pc)
            4'd0:  w = '{UOP_WAIT, REG_B_TAP0, OPD_X,  ACC_NONE, JMP_WAIT_IN,  PC_HOME};
            4'd1:  w = '{UOP_MUL,  REG_B_TAP0, OPD_X,  ACC_NONE, JMP_NEXT,     PC_HOME};
            4'd2:  w = '{UOP_MUL,  REG_B_TAP1, OPD_X1, ACC_ADD,  JMP_NEXT,     PC_HOME};
            4'd3:  w = '{UOP_MUL,  REG_B_TAP2, OPD_X2, ACC_ADD,  JMP_NEXT,     PC_HOME};
            4'd4:  w = '{UOP_MUL,  REG_B_TAP3, OPD_X3, ACC_ADD,  JMP_NEXT,     PC_HOME};
            4'd5:  w = '{UOP_MUL,  REG_A_TAP1, OPD_Y1, ACC_ADD,  JMP_NEXT,     PC_HOME};
            4'd6:  w = '{UOP_MUL,  REG_A_TAP2, OPD_Y2, ACC_SUB,  JMP_NEXT,     PC_HOME};
            4'd7:  w = '{UOP_MUL,  REG_A_TAP3, OPD_Y3, ACC_SUB,  JMP_NEXT,     PC_HOME};
            4'd8:  w = '{UOP_ACC,  REG_A_TAP0, OPD_X,  ACC_SUB,  JMP_NEXT,     PC_HOME};
            4'd9:  w = '{UOP_PREP, REG_A_TAP0, OPD_X,  ACC_NONE, JMP_NEXT,     PC_HOME};
            4'd10: w = '{UOP_DIV,  REG_A_TAP0, OPD_X,  ACC_NONE, JMP_LOOP_DIV, PC_HOME};
            4'd11: w = '{UOP_DONE, REG_A_TAP0, OPD_X,  ACC_NONE, JMP_WAIT_OUT, PC_HOME};
            default: w = '{UOP_WAIT, REG_B_TAP0, OPD_X, ACC_NONE, JMP_WAIT_IN, PC_HOME};
        endcase
        return w;
    endfunction

endpackage

[src/iir_filter_rounded_normalize.sv]
// Top level: handshakes, coefficient registers and the output register.
`timescale 1ns / 1ps

// Direct-form I IIR filter, four feedforward and three feedback taps, with a
// rounded divide by a_tap0. One item is in flight at a time. After the input
// transfer the item passes through seven multiply steps on one shared 16x16
// multiplier, one accumulate step, one setup step, 17 steps of a radix-2
// restoring divider and one write-back step into the output register; the
// next item is taken only in the idle step that follows. The write-back step
// stalls while the output register holds an untaken result.
// The output register holds a finished result while the next item is accepted.
// Products and the sum wrap at 16 bits; a zero a_tap0 gives 0 with divide_fault
// set. Coefficients are written through the cfg port (index 0 to 7:
// b_tap0..b_tap3, a_tap0..a_tap3); other indexes are ignored. Write them only
// while no item is in flight.
module iir_filter_rounded_normalize
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        in_valid,
    output logic        in_ready,
    input  logic [15:0] sample,
    input  logic        start_req,

    output logic        out_valid,
    input  logic        out_ready,
    output logic [15:0] filtered,
    output logic        divide_fault,

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [3:0]  cfg_index,
    input  logic [15:0] cfg_data
);

`include "assert_macros.svh"

    iirrn_pkg::coef_bank_t cfg_reg;
    iirrn_pkg::uword_t     ctrl;
    iirrn_pkg::seq_stat_t  stat;

    logic        in_fire;
    logic        commit;
    logic        div_last;
    logic [15:0] result;
    logic        fault;

    logic        out_valid_reg;
    logic [15:0] filtered_reg;
    logic        fault_reg;

    // Coefficient registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < iirrn_pkg::NREGS; i++)
                cfg_reg[i] <= (i == int'(iirrn_pkg::REG_A_TAP0)) ? 16'd1 : 16'd0;
        end
        else if (cfg_valid && cfg_ready && !cfg_index[3])
        begin
            cfg_reg[cfg_index[2:0]] <= cfg_data;
        end
    end

    // Transfer control
    assign in_ready = (ctrl.uop == iirrn_pkg::UOP_WAIT);
    assign in_fire  = in_valid && in_ready;
    assign commit   = (ctrl.uop == iirrn_pkg::UOP_DONE) && (!out_valid_reg || out_ready);

    assign stat = '{in_fire: in_fire, commit: commit, div_last: div_last};

    iirrn_sequencer u_seq
    (
        .clk   (clk),
        .rst_n (rst_n),
        .stat  (stat),
        .ctrl  (ctrl)
    );

    iirrn_datapath u_dp
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (ctrl),
        .in_fire   (in_fire),
        .commit    (commit),
        .sample    (sample),
        .start_req (start_req),
        .coef      (cfg_reg),
        .result    (result),
        .fault     (fault),
        .div_last  (div_last)
    );

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (commit)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (commit)
        begin
            filtered_reg <= result;
            fault_reg    <= fault;
        end
    end

    assign out_valid    = out_valid_reg;
    assign filtered     = filtered_reg;
    assign divide_fault = fault_reg;

    // Checks
    `IIRRN_ASSERT_NXT(a_busy_after_accept, in_fire, !in_ready, "accepted a second item in flight")
    `IIRRN_ASSERT_NXT(a_commit_shows, commit, out_valid, "committed result not presented")
    `IIRRN_ASSERT_IMP(a_fault_zero, out_valid && divide_fault, filtered == 16'd0,
                      "faulted result is not zero")

endmodule

[src/iirrn_sequencer.sv]
// Microcode sequencer: step counter, control ROM and jump logic.
`timescale 1ns / 1ps

module iirrn_sequencer
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  iirrn_pkg::seq_stat_t stat,
    output iirrn_pkg::uword_t    ctrl
);

    logic [iirrn_pkg::PCW-1:0] pc_reg;
    logic [iirrn_pkg::PCW-1:0] pc_next;

    // Control word for the current step
    assign ctrl = iirrn_pkg::ucode(pc_reg);

    // Next step
    always_comb
    begin
        unique case (ctrl.jmp)
            iirrn_pkg::JMP_NEXT:     pc_next = pc_reg + 1'b1;
            iirrn_pkg::JMP_WAIT_IN:  pc_next = stat.in_fire  ? pc_reg + 1'b1 : pc_reg;
            iirrn_pkg::JMP_LOOP_DIV: pc_next = stat.div_last ? pc_reg + 1'b1 : pc_reg;
            iirrn_pkg::JMP_WAIT_OUT: pc_next = stat.commit   ? ctrl.target   : pc_reg;
            default:                 pc_next = iirrn_pkg::PC_HOME;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pc_reg <= iirrn_pkg::PC_HOME;
        else
            pc_reg <= pc_next;
    end

endmodule

[src/iirrn_datapath.sv]
// Datapath: histories, shared multiplier, accumulator and radix-2 divider.
`timescale 1ns / 1ps

module iirrn_datapath
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  iirrn_pkg::uword_t            ctrl,
    input  logic                         in_fire,
    input  logic                         commit,
    input  logic [iirrn_pkg::DW-1:0]     sample,
    input  logic                         start_req,
    input  iirrn_pkg::coef_bank_t        coef,
    output logic [iirrn_pkg::DW-1:0]     result,
    output logic                         fault,
    output logic                         div_last
);

    localparam int DW = iirrn_pkg::DW;
    localparam int QW = iirrn_pkg::QW;

    // Histories, newest first
    logic [DW-1:0] xh_reg [3];
    logic [DW-1:0] yh_reg [3];

    logic [DW-1:0] x_reg;
    logic [DW-1:0] prod_reg, prod_next;
    logic [DW-1:0] acc_reg, acc_next;

    logic [QW-1:0] quo_reg, quo_next;
    logic [QW-1:0] rem_reg, rem_next;
    logic [QW-1:0] dvs_reg;
    logic          neg_reg;
    logic [iirrn_pkg::CNTW-1:0] cnt_reg;

    logic [DW-1:0]   opd;
    logic [DW-1:0]   cf;
    logic [2*DW-1:0] mult;

    logic [DW-1:0]   a0;
    logic [DW:0]     a0_ext;
    logic [DW:0]     half;
    logic [DW+1:0]   num;
    logic [QW-1:0]   num_mag;
    logic [QW-1:0]   a_mag;

    logic [QW:0]     rem_sh;
    logic [QW+1:0]   diff;
    logic            ge;
    logic [DW-1:0]   q16;

    // Operand select
    always_comb
    begin
        unique case (ctrl.data_sel)
            iirrn_pkg::OPD_X:  opd = x_reg;
            iirrn_pkg::OPD_X1: opd = xh_reg[0];
            iirrn_pkg::OPD_X2: opd = xh_reg[1];
            iirrn_pkg::OPD_X3: opd = xh_reg[2];
            iirrn_pkg::OPD_Y1: opd = yh_reg[0];
            iirrn_pkg::OPD_Y2: opd = yh_reg[1];
            iirrn_pkg::OPD_Y3: opd = yh_reg[2];
            default:           opd = '0;
        endcase
    end

    // Coefficient select; the tap index coef_sel[1:0] is always below TAPS, so no tap is zeroed
    assign cf = ({1'b0, ctrl.coef_sel[1:0]} < 3'(iirrn_pkg::TAPS)) ? coef[ctrl.coef_sel] : '0;

    // Shared multiplier; only the low half matters as the sum wraps at 16 bits
    assign mult      = $signed(cf) * $signed(opd);
    assign prod_next = mult[DW-1:0];

    // Accumulate the product registered in the previous step
    always_comb
    begin
        unique case (ctrl.acc_op)
            iirrn_pkg::ACC_ADD:  acc_next = acc_reg + prod_reg;
            iirrn_pkg::ACC_SUB:  acc_next = acc_reg - prod_reg;
            iirrn_pkg::ACC_NONE: acc_next = acc_reg;
            default:             acc_next = acc_reg;
        endcase
    end

    // Rounded numerator and operand magnitudes
    assign a0      = coef[iirrn_pkg::REG_A_TAP0];
    assign a0_ext  = {a0[DW-1], a0};
    assign half    = $signed(a0_ext + {{DW{1'b0}}, a0[DW-1]}) >>> 1;
    assign num     = {{2{acc_reg[DW-1]}}, acc_reg} + {half[DW], half};
    assign num_mag = num[DW+1] ? QW'(-num) : num[QW-1:0];
    assign a_mag   = a0[DW-1] ? -a0_ext : a0_ext;

    // One restoring divide step
    assign rem_sh   = {rem_reg, quo_reg[QW-1]};
    assign diff     = {1'b0, rem_sh} - {2'b00, dvs_reg};
    assign ge       = !diff[QW+1];
    assign rem_next = ge ? diff[QW-1:0] : rem_sh[QW-1:0];
    assign quo_next = {quo_reg[QW-2:0], ge};

    assign div_last = (cnt_reg == '0);

    // Signed quotient, wrapped to 16 bits
    assign q16    = neg_reg ? -quo_reg[DW-1:0] : quo_reg[DW-1:0];
    assign fault  = (a0 == '0);
    assign result = fault ? '0 : q16;

    // Working registers
    always_ff @(posedge clk)
    begin
        if (in_fire)
            x_reg <= sample;

        unique case (ctrl.uop)
            iirrn_pkg::UOP_WAIT:
            begin
                acc_reg <= '0;
            end
            iirrn_pkg::UOP_MUL:
            begin
                prod_reg <= prod_next;
                acc_reg  <= acc_next;
            end
            iirrn_pkg::UOP_ACC:
            begin
                acc_reg <= acc_next;
            end
            iirrn_pkg::UOP_PREP:
            begin
                quo_reg <= num_mag;
                rem_reg <= '0;
                dvs_reg <= a_mag;
                neg_reg <= num[DW+1] ^ a0[DW-1];
            end
            iirrn_pkg::UOP_DIV:
            begin
                quo_reg <= quo_next;
                rem_reg <= rem_next;
            end
            iirrn_pkg::UOP_DONE:
            begin
                acc_reg <= acc_reg;
            end
            default:
            begin
                acc_reg <= acc_reg;
            end
        endcase
    end

    // Divide iteration counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else if (ctrl.uop == iirrn_pkg::UOP_PREP)
            cnt_reg <= iirrn_pkg::DIV_ITERS_M1;
        else if (ctrl.uop == iirrn_pkg::UOP_DIV && !div_last)
            cnt_reg <= cnt_reg - 1'b1;
    end

    // Histories: cleared by a start request, shifted when the result is committed to the output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 3; i++)
            begin
                xh_reg[i] <= '0;
                yh_reg[i] <= '0;
            end
        end
        else if (in_fire && start_req)
        begin
            for (int i = 0; i < 3; i++)
            begin
                xh_reg[i] <= '0;
                yh_reg[i] <= '0;
            end
        end
        else if (commit)
        begin
            xh_reg[2] <= xh_reg[1];
            xh_reg[1] <= xh_reg[0];
            xh_reg[0] <= x_reg;
            yh_reg[2] <= yh_reg[1];
            yh_reg[1] <= yh_reg[0];
            yh_reg[0] <= result;
        end
    end

endmodule

[tb/tb_iir_filter_rounded_normalize.sv]
// Self-checking testbench for the rounded-normalise direct-form I IIR filter.
`timescale 1ns / 1ps

module tb_iir_filter_rounded_normalize;

    // One filter output as seen on the result channel
    typedef struct packed {
        logic [15:0] filtered;
        logic        divide_fault;
    } filt_result_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;

    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [15:0] sample = '0;
    logic        start_req = 1'b0;

    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [15:0] filtered;
    logic        divide_fault;

    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [3:0]  cfg_index = '0;
    logic [15:0] cfg_data = '0;

    // Shadow of the coefficient bank and of the filter histories
    iirrn_pkg::coef_bank_t coef_now;
    logic [15:0] x_hist [3];
    logic [15:0] y_hist [3];

    filt_result_t pending_outputs [$];

    bit no_stall = 1'b0;
    int errors = 0;
    int samples_sent = 0;
    int outputs_checked = 0;
    int faults_seen = 0;
    int clears_sent = 0;
    int bank_loads = 0;

    iir_filter_rounded_normalize DUT
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .sample       (sample),
        .start_req    (start_req),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .filtered     (filtered),
        .divide_fault (divide_fault),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    // 8 ns clock
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Run limit
    initial
    begin
        #5_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Expected filter output for one sample; advances the shadow histories
    function automatic filt_result_t filter_next(input logic [15:0] x_in, input logic clr);
        longint           acc;
        logic signed [15:0] acc16;
        int               a0;
        int               num;
        int               quo;
        filt_result_t     r;
        if (clr)
        begin
            for (int k = 0; k < 3; k++)
            begin
                x_hist[k] = '0;
                y_hist[k] = '0;
            end
        end
        acc = longint'($signed(coef_now[iirrn_pkg::REG_B_TAP0])) * longint'($signed(x_in));
        for (int k = 1; k < iirrn_pkg::TAPS; k++)
            acc += longint'($signed(coef_now[k])) * longint'($signed(x_hist[k-1]));
        for (int k = 1; k < iirrn_pkg::TAPS; k++)
            acc -= longint'($signed(coef_now[iirrn_pkg::REG_A_TAP0 + k]))
                   * longint'($signed(y_hist[k-1]));
        a0 = $signed(coef_now[iirrn_pkg::REG_A_TAP0]);
        if (a0 == 0)
        begin
            r.filtered = '0;
            r.divide_fault = 1'b1;
        end
        else
        begin
            // wrapped sum plus half the divisor, truncating divide
            acc16 = acc[15:0];
            num = acc16 + a0 / 2;
            quo = num / a0;
            r.filtered = quo[15:0];
            r.divide_fault = 1'b0;
        end
        for (int k = 2; k > 0; k--)
        begin
            x_hist[k] = x_hist[k-1];
            y_hist[k] = y_hist[k-1];
        end
        x_hist[0] = x_in;
        y_hist[0] = r.filtered;
        return r;
    endfunction

    // Coefficient mix: zero, extremes, small values, anything
    function automatic logic [15:0] pick_coef();
        case ($urandom_range(9))
            0:       return 16'h0000;
            1:       return 16'h8000;
            2:       return 16'h7FFF;
            3, 4:    return 16'(int'($urandom_range(8)) - 4);
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [15:0] pick_sample();
        case ($urandom_range(15))
            0:       return 16'h7FFF;
            1:       return 16'h8000;
            2:       return 16'h0000;
            default: return 16'($urandom);
        endcase
    endfunction

    // Result sink: random back-pressure, none while no_stall is set
    always @(posedge clk)
        out_ready <= no_stall || ($urandom_range(99) >= 13);

    // Result checker
    always @(posedge clk)
    begin
        filt_result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_outputs.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected output: filtered=%h fault=%b", filtered, divide_fault);
            end
            else
            begin
                want = pending_outputs.pop_front();
                if (filtered !== want.filtered || divide_fault !== want.divide_fault)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("output %0d: expected filtered=%h fault=%b, got filtered=%h fault=%b",
                                 outputs_checked, want.filtered, want.divide_fault,
                                 filtered, divide_fault);
                end
                if (want.divide_fault)
                    faults_seen++;
            end
            outputs_checked++;
        end
    end

    // Drop the sample valid and let the requested idle gap pass
    task automatic in_idle(input int n);
        in_valid <= 1'b0;
        repeat (n) @(posedge clk);
    endtask

    // Present one sample and hold it until the transfer; valid stays high
    task automatic send_sample(input logic [15:0] x_in, input logic clr);
        sample    <= x_in;
        start_req <= clr;
        in_valid  <= 1'b1;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        pending_outputs.push_back(filter_next(x_in, clr));
        samples_sent++;
        if (clr)
            clears_sent++;
    endtask

    // Sample, sometimes with a random gap in front of it unless no_stall is set
    task automatic feed(input logic [15:0] x_in, input logic clr);
        if (!no_stall && $urandom_range(99) < 13)
            in_idle($urandom_range(8, 1));
        send_sample(x_in, clr);
    endtask

    // Stop sending and wait for every outstanding output
    task automatic wait_drained();
        in_idle(1);
        while (pending_outputs.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // One register write transfer; caller makes sure the filter is idle
    task automatic write_coef(input logic [3:0] idx, input logic [15:0] val);
        cfg_index <= idx;
        cfg_data  <= val;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        if (idx < iirrn_pkg::NREGS)
            coef_now[idx[2:0]] = val;
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic load_coefs(input iirrn_pkg::coef_bank_t bank);
        wait_drained();
        for (int i = 0; i < iirrn_pkg::NREGS; i++)
            write_coef(4'(i), bank[i]);
        bank_loads++;
    endtask

    // Reset coefficients: all b taps zero, so the output is zero
    task automatic test_reset_coefs();
        send_sample(16'h7FFF, 1'b0);
        send_sample(16'h8000, 1'b0);
        send_sample(16'h1234, 1'b1);
    endtask

    // Unity pass-through of the sample extremes
    task automatic test_passthrough();
        iirrn_pkg::coef_bank_t bank;
        bank = '0;
        bank[iirrn_pkg::REG_B_TAP0] = 16'h0001;
        bank[iirrn_pkg::REG_A_TAP0] = 16'h0001;
        load_coefs(bank);
        send_sample(16'h7FFF, 1'b1);
        send_sample(16'h8000, 1'b0);
        send_sample(16'h0000, 1'b0);
        send_sample(16'hFFFF, 1'b0);
    endtask

    // Rounding offset with both divisor signs, and the quotient that wraps
    task automatic test_rounding();
        iirrn_pkg::coef_bank_t bank;
        bank = '0;
        bank[iirrn_pkg::REG_B_TAP0] = 16'h0001;
        bank[iirrn_pkg::REG_A_TAP0] = 16'h0003;
        load_coefs(bank);
        send_sample(16'd5, 1'b1);
        send_sample(-16'sd5, 1'b0);
        wait_drained();
        write_coef(4'(iirrn_pkg::REG_A_TAP0), 16'hFFFC);
        send_sample(16'd6, 1'b0);
        in_idle(1);
        wait_drained();
        // -32768 / -1 overflows and wraps back to -32768
        write_coef(4'(iirrn_pkg::REG_A_TAP0), 16'hFFFF);
        send_sample(16'h8000, 1'b0);
    endtask

    // Zero divisor: output 0 with the fault flag, histories still advance
    task automatic test_zero_divisor();
        iirrn_pkg::coef_bank_t bank;
        bank = '0;
        bank[iirrn_pkg::REG_B_TAP0] = 16'h0003;
        bank[iirrn_pkg::REG_B_TAP1] = 16'h0002;
        load_coefs(bank);
        send_sample(16'd100, 1'b0);
        send_sample(-16'sd7, 1'b0);
    endtask

    // History clear in the middle of a stream with feedback
    task automatic test_start_clears();
        iirrn_pkg::coef_bank_t bank;
        bank = '0;
        bank[iirrn_pkg::REG_B_TAP0] = 16'h0001;
        bank[iirrn_pkg::REG_B_TAP1] = 16'h0001;
        bank[iirrn_pkg::REG_B_TAP2] = 16'h0001;
        bank[iirrn_pkg::REG_B_TAP3] = 16'h0001;
        bank[iirrn_pkg::REG_A_TAP0] = 16'h0001;
        bank[iirrn_pkg::REG_A_TAP1] = 16'hFFFF;
        bank[iirrn_pkg::REG_A_TAP2] = 16'h0001;
        bank[iirrn_pkg::REG_A_TAP3] = 16'hFFFF;
        load_coefs(bank);
        send_sample(16'd1000, 1'b0);
        send_sample(16'd2000, 1'b0);
        send_sample(16'd3000, 1'b0);
        send_sample(16'd4000, 1'b1);
    endtask

    // Writes beyond the register map must leave the bank alone
    task automatic test_ignored_index();
        wait_drained();
        for (int i = iirrn_pkg::NREGS; i < 16; i++)
            write_coef(4'(i), 16'($urandom));
        send_sample(16'h4321, 1'b0);
        send_sample(16'hBCDE, 1'b0);
    endtask

    // Coefficient extremes in both directions
    task automatic test_coef_extremes();
        iirrn_pkg::coef_bank_t bank;
        for (int i = 0; i < iirrn_pkg::NREGS; i++)
            bank[i] = 16'h8000;
        bank[iirrn_pkg::REG_A_TAP0] = 16'h7FFF;
        load_coefs(bank);
        send_sample(16'h7FFF, 1'b0);
        send_sample(16'h8000, 1'b0);
        for (int i = 0; i < iirrn_pkg::NREGS; i++)
            bank[i] = 16'h7FFF;
        bank[iirrn_pkg::REG_A_TAP0] = 16'h8000;
        load_coefs(bank);
        send_sample(16'h8000, 1'b0);
        send_sample(16'h7FFF, 1'b0);
    endtask

    // Random coefficient settings, each followed by a random sample stream
    task automatic test_random_phases();
        iirrn_pkg::coef_bank_t bank;
        for (int p = 0; p < 10; p++)
        begin
            for (int i = 0; i < iirrn_pkg::NREGS; i++)
                bank[i] = pick_coef();
            load_coefs(bank);
            if (p % 3 == 1)
                write_coef(4'(iirrn_pkg::NREGS + $urandom_range(iirrn_pkg::NREGS - 1)),
                           16'($urandom));
            // one whole phase runs without gaps or stalls
            no_stall = (p == 5);
            for (int i = 0; i < 100; i++)
            begin
                // sender holds off until the pipe has emptied
                if (p == 2 && i == 50)
                    wait_drained();
                feed(pick_sample(), $urandom_range(15) == 0);
            end
            no_stall = 1'b0;
        end
    endtask

    initial
    begin
        coef_now = '0;
        coef_now[iirrn_pkg::REG_A_TAP0] = 16'h0001;
        for (int k = 0; k < 3; k++)
        begin
            x_hist[k] = '0;
            y_hist[k] = '0;
        end
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_coefs();
        test_passthrough();
        test_rounding();
        test_zero_divisor();
        test_start_clears();
        test_ignored_index();
        test_coef_extremes();
        test_random_phases();

        wait_drained();
        repeat (30) @(posedge clk);

        $display("%0d samples filtered under %0d coefficient banks, %0d history clears",
                 samples_sent, bank_loads, clears_sent);
        $display("%0d outputs checked, %0d with divide fault, %0d mismatches",
                 outputs_checked, faults_seen, errors);
        if (errors == 0 && pending_outputs.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
